### sv/bsd_pkg.sv
// ----------------------------------------------------------------------------
// Byte-order-mark sniffing text decoder: shared types and functions
// Holds the decoder phase encoding, the state record, the result record and
// the per-byte decode function that the datapath applies up to three times.
// ----------------------------------------------------------------------------
package bsd_pkg;

  // Decoder phase. PH_ERR is UTF-8 after a malformed sequence.
  typedef enum logic [2:0] {
    PH_SNIFF,
    PH_SINGLE,
    PH_UTF8,
    PH_BE,
    PH_LE,
    PH_ERR
  } phase_e;

  // Reported encoding codes.
  localparam logic [1:0] ENC_SINGLE = 2'd0;
  localparam logic [1:0] ENC_UTF8   = 2'd1;
  localparam logic [1:0] ENC_BE     = 2'd2;
  localparam logic [1:0] ENC_LE     = 2'd3;

  // Byte-order-mark bytes.
  localparam logic [7:0] BOM16_FE  = 8'hFE;
  localparam logic [7:0] BOM16_FF  = 8'hFF;
  localparam logic [7:0] BOM8_B0   = 8'hEF;
  localparam logic [7:0] BOM8_B1   = 8'hBB;
  localparam logic [7:0] BOM8_B2   = 8'hBF;

  // Most results that one input byte can cause, and the count width.
  localparam int unsigned MaxResults = 3;
  localparam int unsigned ResCntW    = 2;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  held0;
    logic [7:0]  held1;
    logic [1:0]  held_count;
    logic [15:0] partial;
    logic [1:0]  seq_rem;
    logic        pend_vld;
    logic [7:0]  pend_byte;
    logic        stopped;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    phase:      PH_SNIFF,
    held0:      8'h00,
    held1:      8'h00,
    held_count: 2'd0,
    partial:    16'h0000,
    seq_rem:    2'd0,
    pend_vld:   1'b0,
    pend_byte:  8'h00,
    stopped:    1'b0
  };

  // One result transaction.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        decode_error;
    logic [1:0]  detected_encoding;
    logic        run_last;
  } result_t;

  // Outcome of decoding one byte.
  typedef struct packed {
    dec_state_t state;
    logic       emit;
    result_t    res;
  } step_t;

  // Build a result from the phase in force when it is emitted.
  function automatic result_t bsd_make_result(phase_e ph, logic [15:0] unit, logic last);
    result_t r;
    r.code_unit    = unit;
    r.decode_error = (ph == PH_ERR);
    case (ph)
      PH_SINGLE: r.detected_encoding = ENC_SINGLE;
      PH_BE:     r.detected_encoding = ENC_BE;
      PH_LE:     r.detected_encoding = ENC_LE;
      default:   r.detected_encoding = ENC_UTF8;
    endcase
    r.run_last = last;
    return r;
  endfunction

  // Decode one byte in the phase held by the state (not sniffing).
  function automatic step_t bsd_decode_byte(dec_state_t s_in, logic [7:0] b, logic last);
    dec_state_t  s;
    logic        emit;
    logic        err;
    logic [15:0] unit;
    step_t       r;
    s    = s_in;
    emit = 1'b0;
    err  = 1'b0;
    unit = 16'h0000;
    if (!s.stopped) begin
      case (s.phase)
        PH_SINGLE: begin
          emit = 1'b1;
          unit = {8'h00, b};
        end
        PH_BE, PH_LE: begin
          if (s.pend_vld) begin
            emit        = 1'b1;
            unit        = (s.phase == PH_BE) ? {s.pend_byte, b} : {b, s.pend_byte};
            s.pend_vld  = 1'b0;
            s.pend_byte = 8'h00;
          end else if (last) begin
            // Odd final byte is padded with a zero byte.
            emit = 1'b1;
            unit = (s.phase == PH_BE) ? {b, 8'h00} : {8'h00, b};
          end else begin
            s.pend_vld  = 1'b1;
            s.pend_byte = b;
          end
        end
        PH_UTF8: begin
          if (s.seq_rem == 2'd0) begin
            if (b == 8'h00) begin
              // A zero byte is emitted and stops decoding.
              s.stopped = 1'b1;
              emit      = 1'b1;
            end else if (!b[7]) begin
              emit = 1'b1;
              unit = {8'h00, b};
            end else if (b[7:5] == 3'b110) begin
              s.partial = {5'd0, b[4:0], 6'd0};
              s.seq_rem = 2'd1;
              err       = last;
            end else if (b[7:4] == 4'b1110) begin
              s.partial = {b[3:0], 12'd0};
              s.seq_rem = 2'd2;
              err       = last;
            end else begin
              err = 1'b1;
            end
          end else if (b[7:6] != 2'b10) begin
            err = 1'b1;
          end else begin
            if (s.seq_rem == 2'd2) begin
              s.partial = s.partial | {4'd0, b[5:0], 6'd0};
            end else begin
              s.partial = s.partial | {10'd0, b[5:0]};
            end
            s.seq_rem = s.seq_rem - 2'd1;
            if (s.seq_rem == 2'd0) begin
              emit      = 1'b1;
              unit      = s.partial;
              s.partial = 16'h0000;
            end else begin
              err = last;
            end
          end
        end
        default: ;
      endcase
    end
    // A malformed sequence emits one error result and stops decoding.
    if (err) begin
      s.phase   = PH_ERR;
      s.stopped = 1'b1;
      s.seq_rem = 2'd0;
      s.partial = 16'h0000;
      emit      = 1'b1;
      unit      = 16'h0000;
    end
    // The final byte always yields at least an end marker.
    if (last && !emit) begin
      emit = 1'b1;
      unit = 16'h0000;
    end
    r.state = s;
    r.emit  = emit;
    r.res   = bsd_make_result(s.phase, unit, last);
    return r;
  endfunction

endpackage

### sv/bsd_in_if.sv
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel that carries one document byte per transaction.
// ----------------------------------------------------------------------------
interface bsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

### sv/bsd_out_if.sv
// ----------------------------------------------------------------------------
// Code unit output channel
// Valid/ready channel that carries one decoded code unit per transaction.
// ----------------------------------------------------------------------------
interface bsd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        decode_error;
  logic [1:0]  detected_encoding;
  logic        run_last;

  modport source (
    output valid, output code_unit, output decode_error,
    output detected_encoding, output run_last, input ready
  );
  modport sink (
    input valid, input code_unit, input decode_error,
    input detected_encoding, input run_last, output ready
  );
endinterface

### sv/bom_sniffing_text_decoder.sv
// ----------------------------------------------------------------------------
// Byte-order-mark sniffing text decoder
// Decodes a byte stream as UTF-8, UTF-16BE, UTF-16LE or single bytes into
// 16-bit code units, choosing the encoding from a leading mark.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle in which the result buffer is empty, or holds
// one code unit that leaves in the same cycle; its results appear on the
// output in the next cycle. Most bytes give zero or one code unit, so a steady
// stream moves at one byte per clock. A byte ending a failed mark search
// replays up to two held bytes with itself and can give up to three code
// units; these leave one per cycle from the three-entry buffer while the
// output is ready, and the input waits until the last one is leaving. The
// default_utf8 register selects UTF-8 or single-byte decoding for documents
// without a mark and should only be written while no transaction is in flight.
module bom_sniffing_text_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  bsd_in_if.sink     in_i,
  bsd_out_if.source  out_o
);
  import bsd_pkg::*;

  logic               default_utf8_q;
  dec_state_t         state_q;
  dec_state_t         state_d;
  result_t            buf_q [MaxResults];
  result_t            buf_d [MaxResults];
  result_t            dec_res [MaxResults];
  logic [ResCntW-1:0] dec_cnt;
  logic [ResCntW-1:0] cnt_q;
  logic [ResCntW-1:0] cnt_d;
  logic               accept;
  logic               take;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_utf8_q <= 1'b0;
    end else if (cfg_we_i) begin
      default_utf8_q <= cfg_wdata_i;
    end
  end

  // Handshakes: accept while the buffer will be empty after this cycle.
  assign take        = out_o.valid && out_o.ready;
  assign in_i.ready  = (cnt_q == '0) || ((cnt_q == ResCntW'(1)) && out_o.ready);
  assign accept      = in_i.valid && in_i.ready;

  bsd_decode u_decode (
    .state_i        (state_q),
    .byte_i         (in_i.in_byte),
    .last_i         (in_i.in_last),
    .default_utf8_i (default_utf8_q),
    .state_o        (state_d),
    .res_o          (dec_res),
    .count_o        (dec_cnt)
  );

  // Decoder state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Result buffer: load on a new transaction, otherwise shift on a take.
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (accept) begin
      buf_d = dec_res;
      cnt_d = dec_cnt;
    end else if (take) begin
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
      cnt_d    = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // Output channel shows the head of the buffer.
  assign out_o.valid             = (cnt_q != '0);
  assign out_o.code_unit         = buf_q[0].code_unit;
  assign out_o.decode_error      = buf_q[0].decode_error;
  assign out_o.detected_encoding = buf_q[0].detected_encoding;
  assign out_o.run_last          = buf_q[0].run_last;

endmodule

### sv/bsd_decode.sv
// ----------------------------------------------------------------------------
// Per-byte decode datapath
// Sniffs the byte-order mark, replays held bytes when there is none, decodes
// the byte and packs the resulting code units into a dense list.
// ----------------------------------------------------------------------------
module bsd_decode (
  input  bsd_pkg::dec_state_t state_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic                default_utf8_i,
  output bsd_pkg::dec_state_t state_o,
  output bsd_pkg::result_t    res_o [bsd_pkg::MaxResults],
  output logic [bsd_pkg::ResCntW-1:0] count_o
);
  import bsd_pkg::*;

  dec_state_t            st;
  step_t                 stp0;
  step_t                 stp1;
  step_t                 stp2;
  logic [MaxResults-1:0] rv;
  result_t               rr [MaxResults];
  logic [1:0]            c;
  logic [2:0]            cnew;
  logic [7:0]            h0;
  logic [7:0]            h1;
  logic                  hold;
  logic                  bom;
  phase_e                bom_phase;
  logic [ResCntW-1:0]    n;

  // Mark detection, replay and decode of one accepted byte.
  always_comb begin
    st        = state_i;
    rv        = '0;
    rr[0]     = '0;
    rr[1]     = '0;
    rr[2]     = '0;
    hold      = 1'b0;
    bom       = 1'b0;
    bom_phase = PH_UTF8;
    c         = (state_i.held_count > 2'd2) ? 2'd2 : state_i.held_count;
    cnew      = {1'b0, c} + 3'd1;
    h0        = (c == 2'd0) ? byte_i : state_i.held0;
    h1        = (c == 2'd1) ? byte_i : state_i.held1;
    stp0      = '0;
    stp1      = '0;
    stp2      = '0;
    if (state_i.phase == PH_SNIFF) begin
      case (c)
        2'd0: begin
          if (!last_i && (byte_i == BOM16_FE || byte_i == BOM16_FF || byte_i == BOM8_B0)) begin
            hold = 1'b1;
          end
        end
        2'd1: begin
          if ((h0 == BOM16_FE && byte_i == BOM16_FF) ||
              (h0 == BOM16_FF && byte_i == BOM16_FE)) begin
            bom       = 1'b1;
            bom_phase = (h0 == BOM16_FE) ? PH_BE : PH_LE;
          end else if (!last_i && h0 == BOM8_B0 && byte_i == BOM8_B1) begin
            hold = 1'b1;
          end
        end
        default: begin
          if (h0 == BOM8_B0 && h1 == BOM8_B1 && byte_i == BOM8_B2) begin
            bom       = 1'b1;
            bom_phase = PH_UTF8;
          end
        end
      endcase
      st.held0 = h0;
      st.held1 = h1;
      if (hold) begin
        st.held_count = cnew[1:0];
      end else if (bom) begin
        // The mark itself produces nothing unless it ends the document.
        st.phase      = bom_phase;
        st.held_count = 2'd0;
        if (last_i) begin
          rv[0] = 1'b1;
          rr[0] = bsd_make_result(bom_phase, 16'h0000, 1'b1);
        end
      end else begin
        // No mark: replay the held bytes and this one in the default mode.
        st.phase      = default_utf8_i ? PH_UTF8 : PH_SINGLE;
        st.held_count = 2'd0;
        stp0  = bsd_decode_byte(st, h0, last_i && (cnew == 3'd1));
        st    = stp0.state;
        rv[0] = stp0.emit;
        rr[0] = stp0.res;
        if (cnew >= 3'd2) begin
          stp1  = bsd_decode_byte(st, h1, last_i && (cnew == 3'd2));
          st    = stp1.state;
          rv[1] = stp1.emit;
          rr[1] = stp1.res;
        end
        if (cnew == 3'd3) begin
          stp2  = bsd_decode_byte(st, byte_i, last_i);
          st    = stp2.state;
          rv[2] = stp2.emit;
          rr[2] = stp2.res;
        end
      end
    end else begin
      stp0  = bsd_decode_byte(state_i, byte_i, last_i);
      st    = stp0.state;
      rv[0] = stp0.emit;
      rr[0] = stp0.res;
    end
    // The final byte returns the decoder to its reset state.
    if (last_i) begin
      st = STATE_RESET;
    end
  end

  assign state_o = st;

  // Pack the emitted results to the front of the list.
  always_comb begin
    n        = '0;
    res_o[0] = '0;
    res_o[1] = '0;
    res_o[2] = '0;
    for (int unsigned i = 0; i < MaxResults; i++) begin
      if (rv[i]) begin
        res_o[n] = rr[i];
        n        = n + 1'b1;
      end
    end
  end

  assign count_o = n;

endmodule
